>>> hw/rtl/clso_pkg.sv
// Shared constants, codes and pipeline types for the CPU load sampler with overload check.
package clso_pkg;

   // Field widths
   localparam int TIME_W   = 48;
   localparam int TICK_W   = 64;
   localparam int AGE_W    = 20;
   localparam int THR_RAW_W = 21;
   localparam int THR_W    = 20;
   localparam int MEM_W    = 14;
   localparam int HALF_W   = 32;
   localparam int PROD_W   = HALF_W + THR_W;   // one 32 x 20 partial product
   localparam int CMP_W    = TICK_W + THR_W;   // full 64 x 20 product

   // Stream payload widths
   localparam int REQ_DATA_W = 216;
   localparam int RSP_DATA_W = 8;

   // Threshold normalisation
   localparam logic [THR_W-1:0] THR_PERCENT_LIMIT = 20'd10000;
   localparam logic [THR_W-1:0] THR_FULL_SCALE    = 20'd1000000;
   localparam int               THR_PERCENT_SCALE = 100;
   localparam logic [THR_W-1:0] LOAD_SCALE        = 20'd1000000;

   // Register map
   localparam int  CSR_ADDR_W = 3;
   localparam int  CSR_DATA_W = 32;
   localparam logic REG_FORCE   = 1'b0;
   localparam logic REG_MAX_AGE = 1'b1;
   localparam logic [AGE_W-1:0] MAX_AGE_RESET = 20'd2000;

   // Item kinds
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   // Counter read result; any other code counts as a read error
   typedef enum logic [1:0] {
      READ_OK          = 2'd0,
      READ_UNSUPPORTED = 2'd1,
      READ_ERROR       = 2'd2
   } read_status_type;

   // Result bit positions in rsp_tdata
   localparam int RSP_UNDER_LOAD = 0;
   localparam int RSP_VALID      = 1;
   localparam int RSP_WARMING    = 2;
   localparam int RSP_ERROR      = 3;
   localparam int RSP_SUPPORTED  = 4;

   typedef struct packed {
      logic supported;
      logic err;
      logic warming;
      logic valid;
   } flags_type;

   typedef struct packed {
      logic                        mode;
      logic [TIME_W-1:0]           now_ms;
      logic [1:0]                  read_status;
      logic [TICK_W-1:0]           total_cnt;
      logic [TICK_W-1:0]           idle_cnt;
      logic signed [THR_RAW_W-1:0] threshold_raw;
      logic                        memory_fresh;
      logic [MEM_W-1:0]            memory_used_bp;
   } req_item_type;

   // Decision carried down the pipe: decided items need no CPU compare
   typedef struct packed {
      flags_type flags;
      logic      decided;
      logic      decided_load;
      logic      mem_over;
   } verdict_type;

endpackage

>>> hw/rtl/cpu_load_sampler_overload_check.sv
// Top level: CPU counter sampler with overload query, pipelined over five registers.

// One transaction in, one transaction out. A new item is taken every cycle while the output is
// not stalled; an item passes five registers on its way to rsp_tvalid (input register,
// state update, partial products, product sums, compare into the output register). Samples
// update the stored counters and flags in the state-update stage, so a query directly behind a
// sample already sees it. The overload compare busy*10^6 > threshold*total is exact: four
// 32 x 20 multipliers in one stage, the two 84-bit sums in the next, the compare in the last.
// Flow control is per stage, so a stalled result still lets items move up behind it.
// Registers are to be written only while idle; the user is bound, the block does not enforce it.
module cpu_load_sampler_overload_check
   import clso_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [47:0] now_ms, [49:48] read_status, [113:50] total_cnt, [177:114] idle_cnt,
   // [198:178] threshold_raw, [199] memory_fresh, [213:200] memory_used_bp, [215:214] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] mode
   input  logic                  req_tuser,
   // Response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] under_load, [1] delta_valid, [2] warming_up, [3] read_err,
   // [4] cpu_supported, [7:5] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------- registers
   logic              force_ff;
   logic [AGE_W-1:0]  max_age_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         force_ff   <= 1'b0;
         max_age_ff <= MAX_AGE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[2])
            REG_FORCE:   force_ff   <= csr_pwdata[0];
            REG_MAX_AGE: max_age_ff <= csr_pwdata[AGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FORCE:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, force_ff};
         REG_MAX_AGE: csr_prdata = {{(CSR_DATA_W-AGE_W){1'b0}}, max_age_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign req_tready = rdy0;

   logic fire_a;
   assign fire_a = v0_ff && rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_tvalid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------- input register
   req_item_type item_ff;

   always_ff @(posedge clock) begin
      if (rdy0) begin
         item_ff.mode           <= req_tuser;
         item_ff.now_ms         <= req_tdata[47:0];
         item_ff.read_status    <= req_tdata[49:48];
         item_ff.total_cnt      <= req_tdata[113:50];
         item_ff.idle_cnt       <= req_tdata[177:114];
         item_ff.threshold_raw  <= req_tdata[198:178];
         item_ff.memory_fresh   <= req_tdata[199];
         item_ff.memory_used_bp <= req_tdata[213:200];
      end
   end

   // ---------------------------------------------------------------- sampler state
   logic [TICK_W-1:0] prev_total_ff, prev_total_in;
   logic [TICK_W-1:0] prev_idle_ff, prev_idle_in;
   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   logic [TIME_W-1:0] last_valid_ff, last_valid_in;
   logic [TICK_W-1:0] busy_delta_ff, busy_delta_in;
   logic [TICK_W-1:0] total_delta_ff, total_delta_in;
   logic              have_prev_ff, have_prev_in;
   flags_type         flags_ff, flags_in;

   function automatic logic is_fresh(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] stamp,
                                     input logic [AGE_W-1:0]  age);
      logic [TIME_W-1:0] diff;
      diff = now - stamp;
      return (stamp != '0) && (now >= stamp) && (diff <= {{(TIME_W-AGE_W){1'b0}}, age});
   endfunction

   logic              prev_fresh, valid_fresh;
   logic [TICK_W-1:0] tick_delta, idle_diff;
   logic              advance_ok;

   assign prev_fresh  = is_fresh(item_ff.now_ms, prev_time_ff, max_age_ff);
   assign valid_fresh = is_fresh(item_ff.now_ms, last_valid_ff, max_age_ff);
   assign tick_delta  = item_ff.total_cnt - prev_total_ff;
   assign idle_diff   = item_ff.idle_cnt - prev_idle_ff;
   assign advance_ok  = (item_ff.total_cnt > prev_total_ff)
                     && (item_ff.idle_cnt >= prev_idle_ff)
                     && prev_fresh && (idle_diff <= tick_delta);

   // Sample update
   always_comb begin
      prev_total_in  = prev_total_ff;
      prev_idle_in   = prev_idle_ff;
      prev_time_in   = prev_time_ff;
      last_valid_in  = last_valid_ff;
      busy_delta_in  = busy_delta_ff;
      total_delta_in = total_delta_ff;
      have_prev_in   = have_prev_ff;
      flags_in       = flags_ff;
      if (item_ff.mode == MODE_SAMPLE) begin
         if (item_ff.read_status == READ_UNSUPPORTED) begin
            flags_in     = '{supported: 1'b0, err: 1'b0, warming: 1'b0, valid: 1'b0};
            have_prev_in = 1'b0;
         end else if (item_ff.read_status != READ_OK) begin
            flags_in     = '{supported: 1'b1, err: 1'b1, warming: 1'b0, valid: 1'b0};
            have_prev_in = 1'b0;
         end else begin
            flags_in.supported = 1'b1;
            flags_in.err       = 1'b0;
            if (!have_prev_ff) begin
               flags_in.valid   = 1'b0;
               flags_in.warming = 1'b1;
            end else if (advance_ok) begin
               busy_delta_in    = tick_delta - idle_diff;
               total_delta_in   = tick_delta;
               last_valid_in    = item_ff.now_ms;
               flags_in.valid   = 1'b1;
               flags_in.warming = 1'b0;
            end else begin
               flags_in.valid   = 1'b0;
               flags_in.warming = 1'b0;
            end
            prev_total_in = item_ff.total_cnt;
            prev_idle_in  = item_ff.idle_cnt;
            prev_time_in  = item_ff.now_ms;
            have_prev_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff  <= '0;
         last_valid_ff <= '0;
         have_prev_ff  <= 1'b0;
         flags_ff      <= '{supported: 1'b1, err: 1'b0, warming: 1'b0, valid: 1'b0};
      end else if (fire_a) begin
         prev_time_ff  <= prev_time_in;
         last_valid_ff <= last_valid_in;
         have_prev_ff  <= have_prev_in;
         flags_ff      <= flags_in;
      end
   end

   // Counters and deltas are read only once the flags say they are meaningful
   always_ff @(posedge clock) begin
      if (fire_a) begin
         prev_total_ff  <= prev_total_in;
         prev_idle_ff   <= prev_idle_in;
         busy_delta_ff  <= busy_delta_in;
         total_delta_ff <= total_delta_in;
      end
   end

   // ---------------------------------------------------------------- query decision
   logic [THR_W-1:0]  thr_mag;
   logic [THR_W+6:0]  thr_scaled;
   logic [THR_W-1:0]  thr6;
   logic [MEM_W+6:0]  mem_scaled;
   logic              mem_over;
   verdict_type       verdict;

   assign thr_mag    = item_ff.threshold_raw[THR_W-1:0];
   assign thr_scaled = (THR_W+7)'(thr_mag) * (THR_W+7)'(THR_PERCENT_SCALE);

   // Threshold in millionths: negative clips to zero, small values are hundredths of a percent
   always_comb begin
      if (item_ff.threshold_raw[THR_RAW_W-1])
         thr6 = '0;
      else if (thr_mag <= THR_PERCENT_LIMIT)
         thr6 = thr_scaled[THR_W-1:0];
      else if (thr_mag > THR_FULL_SCALE)
         thr6 = THR_FULL_SCALE;
      else
         thr6 = thr_mag;
   end

   // mem > floor(thr6/100) is the same as 100*mem > thr6
   assign mem_scaled = (MEM_W+7)'(item_ff.memory_used_bp) * (MEM_W+7)'(THR_PERCENT_SCALE);
   assign mem_over   = item_ff.memory_fresh && (mem_scaled > (MEM_W+7)'(thr6));

   always_comb begin
      verdict.flags        = flags_in;
      verdict.mem_over     = mem_over;
      verdict.decided      = 1'b1;
      verdict.decided_load = 1'b0;
      if (item_ff.mode == MODE_QUERY) begin
         if (force_ff)
            verdict.decided_load = 1'b1;
         else if (!flags_ff.supported)
            verdict.decided_load = mem_over;
         else if (flags_ff.warming && !flags_ff.err && !flags_ff.valid
                  && (last_valid_ff == '0) && prev_fresh)
            verdict.decided_load = 1'b0;
         else if (flags_ff.err || !flags_ff.valid || !valid_fresh)
            verdict.decided_load = 1'b1;
         else
            verdict.decided      = 1'b0;
      end
   end

   // ---------------------------------------------------------------- stage 1
   verdict_type       s1_verdict_ff;
   logic [TICK_W-1:0] s1_busy_ff, s1_total_ff;
   logic [THR_W-1:0]  s1_thr_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_verdict_ff <= verdict;
         s1_busy_ff    <= busy_delta_in;
         s1_total_ff   <= total_delta_in;
         s1_thr_ff     <= thr6;
      end
   end

   // ---------------------------------------------------------------- stage 2: partial products
   verdict_type       s2_verdict_ff;
   logic [PROD_W-1:0] pb_lo_ff, pb_hi_ff, pt_lo_ff, pt_hi_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_verdict_ff <= s1_verdict_ff;
         pb_lo_ff <= PROD_W'(s1_busy_ff[HALF_W-1:0]) * PROD_W'(LOAD_SCALE);
         pb_hi_ff <= PROD_W'(s1_busy_ff[TICK_W-1:HALF_W]) * PROD_W'(LOAD_SCALE);
         pt_lo_ff <= PROD_W'(s1_total_ff[HALF_W-1:0]) * PROD_W'(s1_thr_ff);
         pt_hi_ff <= PROD_W'(s1_total_ff[TICK_W-1:HALF_W]) * PROD_W'(s1_thr_ff);
      end
   end

   // ---------------------------------------------------------------- stage 3: product sums
   verdict_type      s3_verdict_ff;
   logic [CMP_W-1:0] busy_prod_ff, thr_prod_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_verdict_ff <= s2_verdict_ff;
         busy_prod_ff  <= {pb_hi_ff, {HALF_W{1'b0}}} + CMP_W'(pb_lo_ff);
         thr_prod_ff   <= {pt_hi_ff, {HALF_W{1'b0}}} + CMP_W'(pt_lo_ff);
      end
   end

   // ---------------------------------------------------------------- stage 4: output register
   logic under_load;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign under_load = s3_verdict_ff.decided ? s3_verdict_ff.decided_load
                     : ((busy_prod_ff > thr_prod_ff) || s3_verdict_ff.mem_over);

   always_ff @(posedge clock) begin
      if (rdy4) begin
         rsp_data_ff <= {3'b000,
                         s3_verdict_ff.flags.supported,
                         s3_verdict_ff.flags.err,
                         s3_verdict_ff.flags.warming,
                         s3_verdict_ff.flags.valid,
                         under_load};
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/clso_checker.sv
// Port-level checker for the CPU load sampler, bound to the top level.
module clso_checker
   import clso_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Nothing comes out in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Unsupported sampling clears every other flag
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tdata[RSP_SUPPORTED] |->
                    !rsp_tdata[RSP_VALID] && !rsp_tdata[RSP_WARMING] && !rsp_tdata[RSP_ERROR])
      else $error("flags set while sampling unsupported");

   // Warm-up and a valid delta exclude each other
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid |-> !(rsp_tdata[RSP_VALID] && rsp_tdata[RSP_WARMING]))
      else $error("valid and warming both set");

   // A failed read leaves no usable delta
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tdata[RSP_ERROR] |-> !rsp_tdata[RSP_VALID])
      else $error("valid set after read error");

endmodule

bind cpu_load_sampler_overload_check clso_checker u_clso_checker (.*);
